/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/tsgc_pkg.sv */
package tsgc_pkg;

    localparam int PosW   = 8;
    localparam int CountW = 8;
    localparam int CfgW   = 8;
    localparam int CfgIdxW = 2;

    localparam logic [CountW-1:0] CountMax = '1;

    // Reset values of the configuration registers.
    localparam logic [CfgW-1:0] SlideThresholdRst = 8'd20;
    localparam logic [CfgW-1:0] TapThresholdRst   = 8'd10;
    localparam logic [CfgW-1:0] HoldMinRst        = 8'd50;
    localparam logic [CfgW-1:0] HoldMaxRst        = 8'd250;

    // Gesture codes carried in the result beat.
    typedef enum logic [2:0] {
        GEST_NONE = 3'd0,
        GEST_FWD  = 3'd1,
        GEST_BACK = 3'd2,
        GEST_TAP  = 3'd3,
        GEST_HOLD = 3'd4
    } gesture_t;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_SLIDE_THRESHOLD = 2'd0,
        REG_TAP_THRESHOLD   = 2'd1,
        REG_HOLD_MIN_TICKS  = 2'd2,
        REG_HOLD_MAX_TICKS  = 2'd3
    } cfg_index_t;

endpackage

/* src/tsgc_channels.sv */
// Input channel: one sensor tick per beat.
interface tsgc_in_if;
    import tsgc_pkg::*;

    logic            valid;
    logic            ready;
    logic            touched;
    logic [PosW-1:0] position;

    modport source (output valid, output touched, output position, input ready);
    modport sink   (input valid, input touched, input position, output ready);
endinterface

// Output channel: one classification result per beat.
interface tsgc_out_if;
    import tsgc_pkg::*;

    logic       valid;
    logic       ready;
    logic       event_valid;
    logic [2:0] gesture;

    modport source (output valid, output event_valid, output gesture, input ready);
    modport sink   (input valid, input event_valid, input gesture, output ready);
endinterface

/* src/touch_slider_gesture_classifier.sv */
// Touch slider gesture classifier.
//
// The samples channel carries one sensor tick per beat: the touch flag and
// the slider position. For every accepted sample beat the gestures channel
// delivers exactly one result beat, in order. event_valid is high on the
// first released tick after a touch (or after reset), and gesture then holds
// the decided class; on all other ticks both fields are zero.
//
// A sample accepted at a clock edge is registered and appears as a result
// after that edge. Throughput is one beat per cycle while the receiver does
// not stall; the press and release counters, start position and last end
// position update in the same cycle the sample is accepted, and the result
// lands in a single output register. When the receiver stalls, the output
// register holds its beat and samples is held off until the beat is taken;
// an accepted result frees the register for a new sample in the same cycle.
//
// Reset clears the counters and positions, empties the output register and loads
// the default thresholds. The configuration port writes one register per cycle
// while cfg_we is high. Use it only while idle; the block does not check.
`include "assert_macros.svh"

module touch_slider_gesture_classifier
    import tsgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tsgc_in_if.sink            samples,
    tsgc_out_if.source         gestures,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata
);

    logic [CfgW-1:0]   slide_threshold_reg;
    logic [CfgW-1:0]   tap_threshold_reg;
    logic [CfgW-1:0]   hold_min_reg;
    logic [CfgW-1:0]   hold_max_reg;

    logic [CountW-1:0] press_ticks_reg, press_ticks_next;
    logic [CountW-1:0] release_ticks_reg, release_ticks_next;
    logic [PosW-1:0]   start_pos_reg, start_pos_next;
    logic [PosW-1:0]   last_end_reg, last_end_next;

    logic              out_valid_reg;
    logic              event_valid_reg, event_valid_next;
    gesture_t          gesture_reg, gesture_next;

    logic              in_fire;
    logic              out_fire;
    logic signed [PosW:0] diff;
    logic [PosW-1:0]   mag;
    gesture_t          slide_class;
    logic              hold_hit;

    // Handshake: the output register takes a new beat when empty or draining.
    assign out_fire      = out_valid_reg && gestures.ready;
    assign samples.ready = !out_valid_reg || gestures.ready;
    assign in_fire       = samples.valid && samples.ready;

    assign gestures.valid       = out_valid_reg;
    assign gestures.event_valid = event_valid_reg;
    assign gestures.gesture     = gesture_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slide_threshold_reg <= SlideThresholdRst;
            tap_threshold_reg   <= TapThresholdRst;
            hold_min_reg        <= HoldMinRst;
            hold_max_reg        <= HoldMaxRst;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SLIDE_THRESHOLD: slide_threshold_reg <= cfg_wdata;
                REG_TAP_THRESHOLD:   tap_threshold_reg   <= cfg_wdata;
                REG_HOLD_MIN_TICKS:  hold_min_reg        <= cfg_wdata;
                REG_HOLD_MAX_TICKS:  hold_max_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Signed end-minus-start; a repeated end counts as no movement.
    always_comb
    begin
        if (samples.position == last_end_reg)
        begin
            diff = '0;
        end
        else
        begin
            diff = $signed({1'b0, samples.position}) - $signed({1'b0, start_pos_reg});
        end
        mag = diff[PosW] ? PosW'(-diff) : diff[PosW-1:0];
    end

    // Slide, tap or none from the movement, then the hold window check.
    always_comb
    begin
        if (!diff[PosW] && (mag != '0) && (mag >= slide_threshold_reg))
        begin
            slide_class = GEST_FWD;
        end
        else if (diff[PosW] && (mag >= slide_threshold_reg))
        begin
            slide_class = GEST_BACK;
        end
        else if ((mag != '0) && (mag < tap_threshold_reg))
        begin
            slide_class = GEST_TAP;
        end
        else
        begin
            slide_class = GEST_NONE;
        end
        hold_hit = (press_ticks_reg > hold_min_reg) && (press_ticks_reg < hold_max_reg);
    end

    // Tick state update and result for the sample at the input.
    always_comb
    begin
        press_ticks_next   = press_ticks_reg;
        release_ticks_next = release_ticks_reg;
        start_pos_next     = start_pos_reg;
        last_end_next      = last_end_reg;
        event_valid_next   = 1'b0;
        gesture_next       = GEST_NONE;

        if (samples.touched)
        begin
            if (press_ticks_reg != CountMax)
            begin
                press_ticks_next = press_ticks_reg + 1'b1;
            end
            if (press_ticks_reg == '0)
            begin
                start_pos_next = samples.position;
            end
            release_ticks_next = '0;
        end
        else
        begin
            if (release_ticks_reg != CountMax)
            begin
                release_ticks_next = release_ticks_reg + 1'b1;
            end
            // First released tick decides the gesture.
            if (release_ticks_reg == '0)
            begin
                last_end_next    = samples.position;
                event_valid_next = 1'b1;
                gesture_next     = hold_hit ? GEST_HOLD : slide_class;
                start_pos_next   = '0;
            end
            press_ticks_next = '0;
        end
    end

    // Tick state registers advance on each accepted sample beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_ticks_reg   <= '0;
            release_ticks_reg <= '0;
            start_pos_reg     <= '0;
            last_end_reg      <= '0;
        end
        else if (in_fire)
        begin
            press_ticks_reg   <= press_ticks_next;
            release_ticks_reg <= release_ticks_next;
            start_pos_reg     <= start_pos_next;
            last_end_reg      <= last_end_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            event_valid_reg <= event_valid_next;
            gesture_reg     <= gesture_next;
        end
    end

    // A result beat with no event carries no gesture.
    `ASSERT_IMPL(a_quiet_tick, out_valid_reg && !event_valid_reg, gesture_reg == GEST_NONE)

    // The first released sample yields a decided result beat.
    `ASSERT_NEXT(a_release_decides, in_fire && !samples.touched && (release_ticks_reg == '0),
                 out_valid_reg && event_valid_reg && (release_ticks_reg != '0))

    // A touched sample leaves a running press count and a cleared release count.
    `ASSERT_NEXT(a_press_counts, in_fire && samples.touched,
                 (press_ticks_reg != '0) && (release_ticks_reg == '0) && !event_valid_reg)

endmodule
